/* hw/rtl/rope_pkg.sv */
// Shared types, register indexes and the sine table generator for the
// rotary embedding phase unit. No dependencies.
package rope_pkg;

    localparam int unsigned PHASE_STEPS_DEF = 4096;
    localparam int unsigned DATA_BITS_DEF   = 24;

    localparam int unsigned CFG_BITS     = 12;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned POS_BITS     = 16;
    localparam int unsigned DIM_BITS     = 12;
    localparam int unsigned TRIG_BITS    = 16;
    localparam int unsigned FREQ_BITS    = 13;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RES_MODE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_OFFSET = 2'd1;

    localparam logic [CFG_BITS-1:0] RES_MODE_RST   = 12'd1;
    localparam logic [CFG_BITS-1:0] DIM_OFFSET_RST = 12'd0;

    localparam longint unsigned TWO_PI_Q30   = 64'd6746518852;
    localparam int unsigned     SERIES_TERMS = 12;
    localparam longint unsigned Q15_ONE_SAT  = 64'd32767;

    // Divisor of series term n is (2n)*(2n+1); entry n-1 holds it.
    localparam logic [SERIES_TERMS-1:0][9:0] SERIES_DIV = {
        10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
        10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
    };

    typedef struct packed {
        logic                        valid;
        logic signed [TRIG_BITS-1:0] sin_val;
        logic signed [TRIG_BITS-1:0] cos_val;
    } t_trig;

    // Magnitude of sin(2*pi*r/2^phase_log) in Q1.15, quarter wave only.
    function automatic logic [TRIG_BITS-2:0] quarter_sin(input longint unsigned r,
                                                         input int unsigned phase_log);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        x    = (TWO_PI_Q30 * r + (64'd1 << (phase_log - 1))) >> phase_log;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= int'(SERIES_TERMS); n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n-1];
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (longint'(sum) + 64'd16384) >> 15;
        if (q > Q15_ONE_SAT) begin
            q = Q15_ONE_SAT;
        end
        return q[TRIG_BITS-2:0];
    endfunction

endpackage

/* hw/rtl/rope_trig_rom.sv */
// Sine and cosine lookup of a full-circle phase from a quarter-wave table.
// Depends on rope_pkg (t_trig, quarter_sin).
module rope_trig_rom
    import rope_pkg::*;
#(
    parameter int unsigned PHASE_STEPS = PHASE_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [$clog2(PHASE_STEPS)-1:0] i_phase,
    output t_trig                          o_trig
);

    localparam int unsigned PL      = $clog2(PHASE_STEPS);
    localparam int unsigned QUARTER = PHASE_STEPS / 4;

    logic [TRIG_BITS-2:0] rom [0:QUARTER];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        localparam logic [TRIG_BITS-2:0] ENTRY = quarter_sin(longint'(g), PL);
        assign rom[g] = ENTRY;
    end

    logic [1:0]    s_quad, c_quad;
    logic [PL-3:0] rem;
    logic [PL-2:0] s_addr, c_addr;

    always_comb begin
        s_quad = i_phase[PL-1:PL-2];
        c_quad = s_quad + 2'd1;
        rem    = i_phase[PL-3:0];
        s_addr = s_quad[0] ? ((PL-1)'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
        c_addr = c_quad[0] ? ((PL-1)'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
    end

    logic [TRIG_BITS-2:0] r_s_mag, r_c_mag;
    logic                 r_s_neg, r_c_neg;
    logic                 r_valid;

    always_ff @(posedge i_clk) begin
        r_s_mag <= rom[s_addr];
        r_c_mag <= rom[c_addr];
        r_s_neg <= s_quad[1];
        r_c_neg <= c_quad[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_comb begin
        o_trig.valid   = r_valid;
        o_trig.sin_val = r_s_neg ? -$signed({1'b0, r_s_mag}) : $signed({1'b0, r_s_mag});
        o_trig.cos_val = r_c_neg ? -$signed({1'b0, r_c_mag}) : $signed({1'b0, r_c_mag});
    end

endmodule

/* hw/rtl/rotary_embedding_quantized_phase_unit.sv */
// Top level of the rotary embedding unit with exact quantized phase.
// Depends on rope_pkg and rope_trig_rom.
//
// Usage:
//   Input channel: raise start with the pair, position and dimension index;
//   the item is taken at the rising edge where start is high and busy is low.
//   busy never rises, so one item can enter every cycle.
//   Result channel: o_strobe marks y_first/y_second for exactly one cycle.
//   There is no back pressure; the receiver must take every item.
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
//   high (0 = res_mode, 1 = dim_offset, others ignored). Write only when idle.
// Throughput: one item per cycle, set by the five-stage pipeline:
//   stage 1 position * res_mode and frequency index, stage 2 phase product,
//   stage 3 quarter-wave sine/cosine table read, stage 4 four products,
//   stage 5 combine, round and saturate into the output register.
// Reset: clears all valid bits (no result in flight survives) and returns
//   res_mode to 1 and dim_offset to 0. Payload registers are not cleared.
module rotary_embedding_quantized_phase_unit
    import rope_pkg::*;
#(
    parameter int unsigned PHASE_STEPS = PHASE_STEPS_DEF,
    parameter int unsigned DATA_BITS   = DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [DATA_BITS-1:0] i_x_first,
    input  logic signed [DATA_BITS-1:0] i_x_second,
    input  logic [POS_BITS-1:0]         i_position,
    input  logic [DIM_BITS-1:0]         i_dim_index,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [CFG_BITS-1:0]         i_cfg_data,
    output logic                        o_strobe,
    output logic signed [DATA_BITS-1:0] o_y_first,
    output logic signed [DATA_BITS-1:0] o_y_second
);

    localparam int unsigned PL = $clog2(PHASE_STEPS);
    localparam int unsigned PW = DATA_BITS + TRIG_BITS;  // one product
    localparam int unsigned SW = PW + 1;                 // sum of two products
    localparam int unsigned RW = SW - 15;                // after rounding shift
    localparam logic signed [SW-1:0] RND_HALF = SW'(16384);
    localparam logic [DATA_BITS-1:0] DMAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic [DATA_BITS-1:0] DMIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    // The pipeline never stalls: accept on every start.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ---------------- configuration registers
    logic [CFG_BITS-1:0] r_res_mode, r_dim_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_mode   <= RES_MODE_RST;
            r_dim_offset <= DIM_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RES_MODE:   r_res_mode   <= i_cfg_data;
                CFG_DIM_OFFSET: r_dim_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: position * res_mode, frequency index
    // Phase is taken mod a power of two, so only the low PL bits matter.
    logic [POS_BITS+CFG_BITS-1:0] pos_prod;
    logic [FREQ_BITS-1:0]         freq_idx;

    always_comb begin
        pos_prod = i_position * r_res_mode;
        freq_idx = {2'b00, i_dim_index[DIM_BITS-1:1]} + FREQ_BITS'(1)
                 + {1'b0, r_dim_offset};
    end

    logic                        r_v1;
    logic [PL-1:0]               r_m1;
    logic [FREQ_BITS-1:0]        r_k1;
    logic signed [DATA_BITS-1:0] r_x1_1, r_x2_1;

    always_ff @(posedge i_clk) begin
        r_m1   <= pos_prod[PL-1:0];
        r_k1   <= freq_idx;
        r_x1_1 <= i_x_first;
        r_x2_1 <= i_x_second;
    end

    // ---------------- stage 2: phase = m * k mod PHASE_STEPS
    logic [PL+FREQ_BITS-1:0] phase_prod;
    assign phase_prod = r_m1 * r_k1;

    logic                        r_v2;
    logic [PL-1:0]               r_phase;
    logic signed [DATA_BITS-1:0] r_x1_2, r_x2_2;

    always_ff @(posedge i_clk) begin
        r_phase <= phase_prod[PL-1:0];
        r_x1_2  <= r_x1_1;
        r_x2_2  <= r_x2_1;
    end

    // ---------------- stage 3: sine and cosine lookup
    t_trig                       trig;
    logic signed [DATA_BITS-1:0] r_x1_3, r_x2_3;

    rope_trig_rom #(
        .PHASE_STEPS(PHASE_STEPS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_phase (r_phase),
        .o_trig  (trig)
    );

    always_ff @(posedge i_clk) begin
        r_x1_3 <= r_x1_2;
        r_x2_3 <= r_x2_2;
    end

    // ---------------- stage 4: four products
    logic                 r_v4;
    logic signed [PW-1:0] r_p1c, r_p2s, r_p2c, r_p1s;

    always_ff @(posedge i_clk) begin
        r_p1c <= r_x1_3 * trig.cos_val;
        r_p2s <= r_x2_3 * trig.sin_val;
        r_p2c <= r_x2_3 * trig.cos_val;
        r_p1s <= r_x1_3 * trig.sin_val;
    end

    // ---------------- stage 5: combine, round, saturate
    // Clamp when the bits above the data sign disagree with it.
    function automatic logic [DATA_BITS-1:0] sat(input logic signed [RW-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[RW-1:DATA_BITS-1];
        hi_zeros = ~|v[RW-1:DATA_BITS-1];
        if (hi_ones || hi_zeros) begin
            return v[DATA_BITS-1:0];
        end
        return v[RW-1] ? DMIN : DMAX;
    endfunction

    logic signed [SW-1:0] acc_a, acc_b;
    logic signed [RW-1:0] rnd_a, rnd_b;

    always_comb begin
        acc_a = SW'(r_p1c) - SW'(r_p2s) + RND_HALF;
        acc_b = SW'(r_p2c) + SW'(r_p1s) + RND_HALF;
        rnd_a = $signed(acc_a[SW-1:15]);
        rnd_b = $signed(acc_b[SW-1:15]);
    end

    logic r_v5;

    always_ff @(posedge i_clk) begin
        o_y_first  <= $signed(sat(rnd_a));
        o_y_second <= $signed(sat(rnd_b));
    end

    // ---------------- valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v4 <= trig.valid;
            r_v5 <= r_v4;
        end
    end

    assign o_strobe = r_v5;

    // ---------------- checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_v1, 4))
        else $error("result strobe without an item four stages back");

    a_zero_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && $past(r_res_mode) == '0) |-> r_m1 == '0)
        else $error("zero res_mode gave a nonzero phase factor");

    a_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig.valid |-> (trig.sin_val != DMIN[DATA_BITS-1 -: TRIG_BITS]
                        && trig.cos_val != DMIN[DATA_BITS-1 -: TRIG_BITS]))
        else $error("table value outside Q1.15 magnitude");

    a_quadrature: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig.valid |-> (trig.sin_val != '0 || trig.cos_val != '0))
        else $error("sine and cosine both zero");

endmodule

/* verif/rotary_embedding_quantized_phase_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rotary_embedding_quantized_phase_unit: directed and random
// items are checked against a scoreboard that predicts each rotated pair.
// Depends on rope_pkg and the unit's RTL.

module rotary_embedding_quantized_phase_unit_tb;
    import rope_pkg::*;

    typedef longint unsigned u64_t;

    localparam int DB            = DATA_BITS_DEF;
    localparam int PHASES        = PHASE_STEPS_DEF;
    localparam int QUARTER       = PHASES / 4;
    localparam int TAYLOR_TERMS  = 12;
    localparam int TRIG_ONE      = 32767;          // +1.0 held just below one in Q1.15
    localparam u64_t ANGLE_TURN_Q30 = 64'd6746518852;

    localparam longint DATA_MAX = (longint'(1) << (DB - 1)) - 1;
    localparam longint DATA_MIN = -(longint'(1) << (DB - 1));
    localparam logic signed [DB-1:0] X_MAX = {1'b0, {(DB - 1){1'b1}}};
    localparam logic signed [DB-1:0] X_MIN = {1'b1, {(DB - 1){1'b0}}};

    // Indexes past the two real registers; the unit must ignore writes there.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    localparam int CLK_HALF_NS      = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 8;
    localparam int IDLE_LIMIT       = 1000;  // cycles with no traffic at all
    localparam int PRINT_CAP        = 30;
    localparam int RANDOM_PER_PHASE = 210;
    localparam int NUM_SETTINGS     = 8;

    typedef struct {
        int                     seq;
        logic signed [DB-1:0]   y_first;
        logic signed [DB-1:0]   y_second;
    } rotated_t;

    int mismatches = 0;

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // Scoreboard: keeps its own copy of the registers and the sine table, turns each
    // accepted item into the expected rotated pair, and checks results in order.
    class rotation_scoreboard;
        int                  quarter_wave [0:QUARTER];
        logic [CFG_BITS-1:0] res_mode;
        logic [CFG_BITS-1:0] dim_offset;
        rotated_t            rotated_q [$];
        int                  taken;

        function new();
            build_quarter_wave();
            reset_regs();
            taken = 0;
        endfunction

        // Quarter-wave sine in Q1.15: Q30 angle, truncated Taylor terms, round to Q15.
        function void build_quarter_wave();
            u64_t   ang;
            u64_t   ang_sq;
            u64_t   term;
            u64_t   rnd;
            longint acc;
            for (int r = 0; r <= QUARTER; r++) begin
                ang    = (ANGLE_TURN_Q30 * u64_t'(r) + u64_t'(PHASES / 2)) / u64_t'(PHASES);
                ang_sq = (ang * ang) >> 30;
                term   = ang;
                acc    = longint'(ang);
                for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                    term = ((term * ang_sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                rnd = (u64_t'(acc) + 64'd16384) >> 15;
                quarter_wave[r] = (rnd > u64_t'(TRIG_ONE)) ? TRIG_ONE : int'(rnd);
            end
        endfunction

        function void reset_regs();
            res_mode   = RES_MODE_RST;
            dim_offset = DIM_OFFSET_RST;
        endfunction

        function void set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_BITS-1:0] val);
            if (idx == CFG_RES_MODE) begin
                res_mode = val;
            end else if (idx == CFG_DIM_OFFSET) begin
                dim_offset = val;
            end
        endfunction

        // Full-circle sine from quarter-wave symmetry.
        function int wave_at(input int p);
            int quad;
            int r;
            quad = (p / QUARTER) % 4;
            r    = p % QUARTER;
            case (quad)
                0: return quarter_wave[r];
                1: return quarter_wave[QUARTER - r];
                2: return -quarter_wave[r];
                default: return -quarter_wave[QUARTER - r];
            endcase
        endfunction

        // Round Q.31 back to Q8.16 (ties go up), then clamp to the data range.
        function logic signed [DB-1:0] round_to_data(input longint acc);
            longint v;
            v = (acc + 64'sd16384) >>> 15;
            if (v > DATA_MAX) begin
                v = DATA_MAX;
            end
            if (v < DATA_MIN) begin
                v = DATA_MIN;
            end
            return v[DB-1:0];
        endfunction

        function void note_pair(input logic signed [DB-1:0] x1, x2,
                                input logic [POS_BITS-1:0] pos,
                                input logic [DIM_BITS-1:0] dim);
            u64_t     freq;
            u64_t     ph;
            int       sn;
            int       cs;
            rotated_t e;
            freq = (u64_t'(dim) >> 1) + 1 + u64_t'(dim_offset);
            ph   = (u64_t'(pos) * u64_t'(res_mode) * freq) % u64_t'(PHASES);
            sn   = wave_at(int'(ph));
            cs   = wave_at(int'((ph + u64_t'(QUARTER)) % u64_t'(PHASES)));
            e.seq      = taken;
            e.y_first  = round_to_data(longint'(x1) * cs - longint'(x2) * sn);
            e.y_second = round_to_data(longint'(x2) * cs + longint'(x1) * sn);
            rotated_q.push_back(e);
            taken++;
        endfunction

        task check_rotation(input logic signed [DB-1:0] y1, y2);
            rotated_t e;
            if (rotated_q.size() == 0) begin
                report_mismatch($sformatf("result y_first=%0d y_second=%0d, no item waiting",
                                          y1, y2));
                return;
            end
            e = rotated_q.pop_front();
            if (y1 !== e.y_first) begin
                report_mismatch($sformatf("item %0d y_first got %0d want %0d",
                                          e.seq, y1, e.y_first));
            end
            if (y2 !== e.y_second) begin
                report_mismatch($sformatf("item %0d y_second got %0d want %0d",
                                          e.seq, y2, e.y_second));
            end
        endtask

        function int outstanding();
            return rotated_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic signed [DB-1:0]      i_x_first   = '0;
    logic signed [DB-1:0]      i_x_second  = '0;
    logic [POS_BITS-1:0]       i_position  = '0;
    logic [DIM_BITS-1:0]       i_dim_index = '0;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx   = '0;
    logic [CFG_BITS-1:0]       i_cfg_data  = '0;
    logic                      o_strobe;
    logic signed [DB-1:0]      o_y_first;
    logic signed [DB-1:0]      o_y_second;

    rotation_scoreboard board;
    int                 idle_run = 0;

    rotary_embedding_quantized_phase_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_x_first   (i_x_first),
        .i_x_second  (i_x_second),
        .i_position  (i_position),
        .i_dim_index (i_dim_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_y_first   (o_y_first),
        .o_y_second  (o_y_second)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Monitor: sample everything at the rising edge, before the block's own
    // updates land, so register writes, accepted items and results are seen
    // exactly as the block sees them. Also run the idle watchdog here.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            board.reset_regs();
        end else begin
            if (i_cfg_we) begin
                board.set_reg(i_cfg_idx, i_cfg_data);
                moved = 1'b1;
            end
            // Note the item first: its result cannot arrive on the same edge.
            if (start && busy === 1'b0) begin
                board.note_pair(i_x_first, i_x_second, i_position, i_dim_index);
                moved = 1'b1;
            end
            if (o_strobe === 1'b1) begin
                board.check_rotation(o_y_first, o_y_second);
                moved = 1'b1;
            end else if (o_strobe !== 1'b0) begin
                report_mismatch("o_strobe is unknown");
            end
        end
        idle_run <= moved ? 0 : idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random pickers: mostly short gaps, a few long ones; data weighted
    // toward the range ends so saturation and sign cases come up often.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        if (sel < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [DB-1:0] pick_sample();
        int sel;
        logic signed [DB-1:0] v;
        sel = $urandom_range(99);
        if (sel < 55) begin
            v = $urandom;
        end else if (sel < 75) begin
            v = $urandom_range(0, 1023) - 512;
        end else if (sel < 90) begin
            case ($urandom_range(3))
                0: v = X_MAX;
                1: v = X_MIN;
                2: v = '0;
                default: v = '1;
            endcase
        end else if (sel < 95) begin
            v = X_MAX - $urandom_range(255);
        end else begin
            v = X_MIN + $urandom_range(255);
        end
        return v;
    endfunction

    function automatic logic [POS_BITS-1:0] pick_position();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) return $urandom;
        if (sel < 88) return $urandom_range(0, 64);
        if (sel < 94) return '1;
        return '0;
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_dim();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) return $urandom;
        case ($urandom_range(3))
            0: return '0;
            1: return 1;
            2: return '1 - 1;
            default: return '1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks. Hold start high across back-to-back items; drop it only
    // when a gap follows, so start never sees two assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_pair(input logic signed [DB-1:0] x1, x2,
                             input logic [POS_BITS-1:0] pos,
                             input logic [DIM_BITS-1:0] dim,
                             input int gap);
        start       <= 1'b1;
        i_x_first   <= x1;
        i_x_second  <= x2;
        i_position  <= pos;
        i_dim_index <= dim;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One write, then the enable is dropped and held low until the task returns, so it never toggles twice in a step.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected result, then let the pipe go quiet.
    task automatic drain_results();
        start <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Directed items at the reset register values (res_mode 1, dim_offset 0),
    // so the phase is position * (dim_index/2 + 1).
    task automatic run_directed();
        send_pair('0, '0, 0, 0, pick_gap());
        // zero phase: cosine held just below one shrinks the pair slightly
        send_pair(X_MAX, X_MIN, 0, 0, pick_gap());
        send_pair(X_MIN, X_MAX, 0, 12'hFFF, pick_gap());
        // eighth turn: both sine and cosine near 0.707, one sum of each pair overflows and clamps
        send_pair(X_MAX, X_MAX, 512, 0, pick_gap());
        send_pair(X_MAX, X_MIN, 512, 1, pick_gap());
        send_pair(X_MIN, X_MAX, 512, 0, pick_gap());
        send_pair(X_MIN, X_MIN, 512, 0, pick_gap());
        // quarter turn with exact half-step ties in the rounding
        send_pair(24'sd16384, 24'sd16384, 1024, 0, pick_gap());
        send_pair(-24'sd16384, -24'sd16384, 1024, 0, pick_gap());
        send_pair(X_MAX, '0, 1024, 0, pick_gap());
        // quadrant boundaries and the last step of the circle
        send_pair(24'sd12345, -24'sd54321, 2048, 0, pick_gap());
        send_pair(-24'sd777777, 24'sd333333, 3072, 0, pick_gap());
        send_pair(24'sd4000000, 24'sd100, 4095, 0, pick_gap());
        send_pair(24'sd65536, -24'sd65536, 16'hFFFF, 0, pick_gap());
        // largest position and index: frequency 2048, phase lands on a half turn
        send_pair(-24'sd65536, 24'sd131072, 16'hFFFF, 12'hFFF, pick_gap());
        send_pair(24'sd98304, 24'sd1, 1, 12'hFFE, pick_gap());
        // single steps of phase, odd index halved down
        send_pair(-24'sd1, 24'sd1, 1, 0, pick_gap());
        send_pair(24'sd1, -24'sd1, 1023, 3, pick_gap());
        // alternating bit patterns on every field
        send_pair(24'sh555555, 24'shAAAAAA, 16'hAAAA, 12'h555, pick_gap());
        send_pair(24'shAAAAAA, 24'sh555555, 16'h5555, 12'hAAA, 1);
    endtask

    // Random items: mostly runs over consecutive pairs of one token (as a head
    // vector streams in), the rest lone items with random index and position.
    task automatic run_random(input int count, input bit steady);
        int                  sent;
        int                  len;
        logic [POS_BITS-1:0] pos;
        logic [DIM_BITS-1:0] dim;
        sent = 0;
        while (sent < count) begin
            pos = pick_position();
            if ($urandom_range(2) != 0) begin
                dim = $urandom_range(0, 31) * 2;
                len = $urandom_range(4, 32);
            end else begin
                dim = pick_dim();
                len = 1;
            end
            for (int i = 0; i < len && sent < count; i++) begin
                send_pair(pick_sample(), pick_sample(), pos, dim, steady ? 0 : pick_gap());
                dim = dim + 2;
                sent++;
                // now and then, hold off until the pipe is empty
                if ($urandom_range(149) == 0) begin
                    drain_results();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed items, then one random phase per
    // register setting, draining fully before every register write.
    // ------------------------------------------------------------------
    initial begin
        logic [CFG_BITS-1:0] res;
        logic [CFG_BITS-1:0] off;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(RANDOM_PER_PHASE, 1'b0);
        drain_results();

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            case (ph)
                0: begin res = '0; off = '1; end      // zero multiplier: phase always 0
                1: begin res = '1; off = '1; end
                2: begin res = '1; off = '0; end
                3: begin res = 1;  off = '0; end
                7: begin res = $urandom_range(1, 8); off = $urandom_range(0, 3); end
                default: begin res = $urandom; off = $urandom; end
            endcase
            write_reg(CFG_RES_MODE, res);
            write_reg(CFG_DIM_OFFSET, off);
            // writes past the real registers must leave both untouched
            write_reg((ph % 2 == 0) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
            run_random(RANDOM_PER_PHASE, ph % 3 == 2);
            drain_results();
        end

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
